// ===== rtl/dpcp_pkg.sv =====
// ============================================================================
// dpcp_pkg
// Shared types and constants for the delta patch command parser.
// ============================================================================
package dpcp_pkg;

    // Parse phase, one-hot
    typedef enum logic [4:0] {
        PH_HEADER   = 5'b00001,
        PH_SKIP     = 5'b00010,
        PH_LENGTH   = 5'b00100,
        PH_COPY_OFF = 5'b01000,
        PH_DONE     = 5'b10000
    } t_phase;

    // Result status codes
    localparam logic [1:0] ST_CMD       = 2'd0;
    localparam logic [1:0] ST_DONE      = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    // Command type codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_COPY = 1'b1;

    // Header and field geometry
    localparam logic [33:0] ADD_POS_START = 34'd8;
    localparam logic [32:0] BASE_BIAS     = 33'd8;
    localparam logic [2:0]  HDR_COUNT_END = 3'd4;

    // Parser state
    typedef struct packed {
        t_phase      phase;
        logic [2:0]  byte_index;
        logic [31:0] word_shift;
        logic [31:0] commands_left;
        logic [31:0] skip_left;
        logic [33:0] add_position;
        logic [32:0] relative_base;
        logic        next_is_copy;
        logic [31:0] held_length;
    } t_state;

    // One result item
    typedef struct packed {
        logic        cmd_type;
        logic [33:0] cmd_offset;
        logic [31:0] cmd_length;
        logic [1:0]  status;
    } t_result;

    // State after reset or after end of input
    localparam t_state STATE_CLEAR = '{
        phase:         PH_HEADER,
        byte_index:    3'd0,
        word_shift:    32'd0,
        commands_left: 32'd0,
        skip_left:     32'd0,
        add_position:  ADD_POS_START,
        relative_base: 33'd0,
        next_is_copy:  1'b0,
        held_length:   32'd0
    };

endpackage

// ===== rtl/delta_patch_command_parser.sv =====
// ============================================================================
// delta_patch_command_parser
// Parses a byte stream of a delta patch into add and copy command items.
// ============================================================================
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready | i_data_byte, i_end_of_input
//  output   | o_out_valid/ i_out_ready| o_cmd_type, o_cmd_offset, o_cmd_length,
//           |                         | o_status
//  config   | i_cfg_we                | i_cfg_wdata (offset_relative)
//
//  One input item per cycle unless a waiting result stalls it. Each item is
//  decoded combinationally from the state registers into next state and result.
//  Reset clears the parse state, the relative-offset mode and the result valid.
//  A waiting result blocks input only when it is not taken in the same cycle;
//  items that produce no result still need the result register free or draining.
//
module delta_patch_command_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_cmd_type,
    output logic [33:0] o_cmd_offset,
    output logic [31:0] o_cmd_length,
    output logic [1:0]  o_status
);
    import dpcp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result step_result;
    logic    step_valid;
    logic    r_out_valid;
    logic    r_offset_relative;
    logic    in_fire;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Per-item decode
    dpcp_step u_step (
        .i_state           (r_state),
        .i_offset_relative (r_offset_relative),
        .i_data_byte       (i_data_byte),
        .i_end_of_input    (i_end_of_input),
        .o_next_state      (n_state),
        .o_result          (step_result),
        .o_result_valid    (step_valid)
    );

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_relative <= 1'b0;
        end else if (i_cfg_we) begin
            r_offset_relative <= i_cfg_wdata;
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= step_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_fire && step_valid) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cmd_type   = r_result.cmd_type;
    assign o_cmd_offset = r_result.cmd_offset;
    assign o_cmd_length = r_result.cmd_length;
    assign o_status     = r_result.status;

endmodule

// ===== rtl/dpcp_step.sv =====
// ============================================================================
// dpcp_step
// Next-state and result logic for one patch byte or end-of-input marker.
// ============================================================================
module dpcp_step (
    input  dpcp_pkg::t_state  i_state,
    input  logic              i_offset_relative,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_input,
    output dpcp_pkg::t_state  o_next_state,
    output dpcp_pkg::t_result o_result,
    output logic              o_result_valid
);
    import dpcp_pkg::*;

    logic [31:0] shifted;
    logic [2:0]  hdr_index;
    logic [2:0]  word_index;
    logic [31:0] cmds_dec;
    logic [31:0] skip_dec;
    logic [33:0] rel_offset;
    logic [33:0] copy_offset;

    // Shared datapath pieces
    assign shifted    = {i_state.word_shift[23:0], i_data_byte};
    assign hdr_index  = i_state.byte_index + 3'd1;
    assign word_index = {1'b0, i_state.byte_index[1:0] + 2'd1};
    assign cmds_dec   = i_state.commands_left - 32'd1;
    assign skip_dec   = i_state.skip_left - 32'd1;
    // base plus sign-extended offset, wraps at 34 bits
    assign rel_offset  = {1'b0, i_state.relative_base} + {{2{shifted[31]}}, shifted};
    assign copy_offset = i_offset_relative ? rel_offset : {2'b00, shifted};

    // Per-phase update
    always_comb begin
        o_next_state   = i_state;
        o_result       = '0;
        o_result_valid = 1'b0;
        if (i_end_of_input) begin
            o_next_state    = STATE_CLEAR;
            o_result.status = (i_state.phase == PH_COPY_OFF) ? ST_TRUNCATED : ST_DONE;
            o_result_valid  = 1'b1;
        end else begin
            case (i_state.phase)
                PH_HEADER: begin
                    o_next_state.byte_index = hdr_index;
                    o_next_state.word_shift = shifted;
                    if (hdr_index == HDR_COUNT_END) begin
                        o_next_state.commands_left = shifted;
                        o_next_state.word_shift    = 32'd0;
                    end else if (hdr_index == 3'd0) begin
                        o_next_state.skip_left     = shifted;
                        o_next_state.relative_base = BASE_BIAS + {1'b0, shifted};
                        o_next_state.word_shift    = 32'd0;
                        if (shifted != 32'd0) begin
                            o_next_state.phase = PH_SKIP;
                        end else begin
                            o_next_state.phase = (i_state.commands_left != 32'd0)
                                                 ? PH_LENGTH : PH_DONE;
                        end
                    end
                end
                PH_SKIP: begin
                    o_next_state.skip_left = skip_dec;
                    if (skip_dec == 32'd0) begin
                        o_next_state.phase      = (i_state.commands_left != 32'd0)
                                                  ? PH_LENGTH : PH_DONE;
                        o_next_state.byte_index = 3'd0;
                        o_next_state.word_shift = 32'd0;
                    end
                end
                PH_LENGTH: begin
                    o_next_state.byte_index = word_index;
                    o_next_state.word_shift = shifted;
                    if (word_index == 3'd0) begin
                        o_next_state.commands_left = cmds_dec;
                        o_next_state.word_shift    = 32'd0;
                        if (!i_state.next_is_copy) begin
                            // add: data offset runs by the add lengths
                            o_next_state.next_is_copy = 1'b1;
                            o_next_state.add_position = i_state.add_position
                                                        + {2'b00, shifted};
                            o_next_state.phase        = (cmds_dec != 32'd0)
                                                        ? PH_LENGTH : PH_DONE;
                            o_result.cmd_type   = CMD_ADD;
                            o_result.cmd_offset = i_state.add_position;
                            o_result.cmd_length = shifted;
                            o_result.status     = ST_CMD;
                            o_result_valid      = (shifted != 32'd0);
                        end else begin
                            // copy: hold length, read offset next
                            o_next_state.held_length = shifted;
                            o_next_state.phase       = PH_COPY_OFF;
                        end
                    end
                end
                PH_COPY_OFF: begin
                    o_next_state.byte_index = word_index;
                    o_next_state.word_shift = shifted;
                    if (word_index == 3'd0) begin
                        o_next_state.next_is_copy = 1'b0;
                        o_next_state.held_length  = 32'd0;
                        o_next_state.word_shift   = 32'd0;
                        o_next_state.phase        = (i_state.commands_left != 32'd0)
                                                    ? PH_LENGTH : PH_DONE;
                        o_result.cmd_type   = CMD_COPY;
                        o_result.cmd_offset = copy_offset;
                        o_result.cmd_length = i_state.held_length;
                        o_result.status     = ST_CMD;
                        o_result_valid      = (i_state.held_length != 32'd0);
                    end
                end
                PH_DONE: begin
                    // trailing bytes are dropped
                    o_next_state = i_state;
                end
                default: begin
                    o_next_state = i_state;
                end
            endcase
        end
    end

endmodule
